FILE: rtl/neighbour_heading_alignment_macros.svh
// ----------------------------------------------------------------------------
// Neighbour heading alignment assertion macros
// Shared property forms; the using module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_HEADING_ALIGNMENT_MACROS_SVH
`define NEIGHBOUR_HEADING_ALIGNMENT_MACROS_SVH

// same-cycle implication
`define NHA_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nha_pkg.sv
// ----------------------------------------------------------------------------
// nha_pkg
// Shared constants, codes and structs of the neighbour heading alignment block.
// ----------------------------------------------------------------------------
`default_nettype none

package nha_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int MAX_RESULTS = 9;
    localparam int CNT_W = $clog2(MAX_RESULTS);
    // angle frames allowed per send cycle, after the ID broadcast
    localparam logic [CNT_W-1:0] FRAME_CAP = CNT_W'(MAX_RESULTS - 1);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [3:0] FRAME_BCAST = 4'hF;
    localparam logic [9:0] SPEED_LIMIT = 10'd1000;

    localparam logic [3:0]  OWN_ID_RST = 4'd0;
    localparam logic [31:0] TTL_RST    = 32'd30000;
    localparam logic [14:0] OSTEP_RST  = 15'd910;
    localparam logic [14:0] TSTEP_RST  = 15'd1267;
    localparam logic [9:0]  TSPEED_RST = 10'd100;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_TICK  = 2'd1,
        OP_SEND  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_REPORT = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_MOTOR  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ID     = 3'd0,
        CFG_TTL        = 3'd1,
        CFG_OSTEP      = 3'd2,
        CFG_TSTEP      = 3'd3,
        CFG_TURN_SPEED = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  id;
        logic [15:0] angle;
        logic [2:0]  sensor;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic             full;   // 1: whole entry, 0: angle and sensor only
        logic [IDX_W-1:0] idx;
        logic [3:0]       id;
        logic [15:0]      angle;
        logic [2:0]       sensor;
        logic [31:0]      seen;
    } tbl_wr_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] p;
        logic [15:0] q;
        logic        sub;
    } unit_req_t;

    typedef struct packed {
        logic [31:0] diff;
        logic [15:0] sum;
    } unit_rsp_t;

    // 0x8000 plus the slice angle round(s * 65536 / 15), modulo 65536
    function automatic logic [15:0] align_bias(input logic [3:0] s);
        logic [15:0] b;
        case (s)
            4'd0:    b = 16'd32768;
            4'd1:    b = 16'd37137;
            4'd2:    b = 16'd41506;
            4'd3:    b = 16'd45875;
            4'd4:    b = 16'd50244;
            4'd5:    b = 16'd54613;
            4'd6:    b = 16'd58982;
            4'd7:    b = 16'd63351;
            4'd8:    b = 16'd2185;
            4'd9:    b = 16'd6554;
            4'd10:   b = 16'd10923;
            4'd11:   b = 16'd15292;
            4'd12:   b = 16'd19661;
            4'd13:   b = 16'd24030;
            4'd14:   b = 16'd28399;
            default: b = 16'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/neighbour_heading_alignment.sv
// ----------------------------------------------------------------------------
// neighbour_heading_alignment
// Neighbour table and own heading; a sequencer drives one shared unit.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | operation frame_value frame_error
//          |                     | arrival_angle arrival_sensor now
//  out     | out_valid/out_stall | result_kind frame_out left_speed
//          |                     | right_speed heading_now last_of_run
//  cfg     | cfg_valid/cfg_ready | cfg_index cfg_data
//
//  One request at a time; in_stall is high from accept until the final result
//  is loaded into the output register. The table scan visits one entry a cycle
//  unless a send scan waits on out_stall. Broadcast frame: scan, insert, result;
//  aligning frame: align, result; ignored frame: result only; motion tick and
//  send cycle: scan, result. Operation 3 gives no result.
//  Reset clears valid bits and heading and restores configuration defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "neighbour_heading_alignment_macros.svh"

module neighbour_heading_alignment
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire logic [1:0]                      operation,
    input  wire logic [7:0]                      frame_value,
    input  wire logic                            frame_error,
    input  wire logic signed [15:0]              arrival_angle,
    input  wire logic [2:0]                      arrival_sensor,
    input  wire logic [31:0]                     now,

    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      logic [1:0]                      result_kind,
    output      logic [7:0]                      frame_out,
    output      logic signed [10:0]              left_speed,
    output      logic signed [10:0]              right_speed,
    output      logic signed [15:0]              heading_now,
    output      logic                            last_of_run,

    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [nha_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nha_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_ALIGN = 5'b01000,
        ST_FINAL = 5'b10000
    } state_t;

    localparam int IW = nha_pkg::IDX_W;
    localparam int CW = nha_pkg::CNT_W;

    state_t state_reg, state_next;

    logic [3:0]  own_id_reg, own_id_next;
    logic [31:0] ttl_reg, ttl_next;
    logic [14:0] ostep_reg, ostep_next;
    logic [14:0] tstep_reg, tstep_next;
    logic [9:0]  tspeed_reg, tspeed_next;
    logic [15:0] heading_reg, heading_next;

    logic [1:0]  op_reg, op_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic        match_hit_reg, match_hit_next;
    logic        free_hit_reg, free_hit_next;
    logic        old_hit_reg, old_hit_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;

    logic [3:0]  nid_reg, nid_next;
    logic [15:0] arrival_reg, arrival_next;
    logic [2:0]  sensor_reg, sensor_next;
    logic [31:0] now_reg, now_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] rot_reg, rot_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic [31:0] old_age_reg, old_age_next;
    logic [1:0]  fin_kind_reg, fin_kind_next;
    logic [7:0]  fin_frame_reg, fin_frame_next;
    logic [10:0] fin_left_reg, fin_left_next;
    logic [10:0] fin_right_reg, fin_right_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  frame_reg, frame_next;
    logic [10:0] left_reg, left_next;
    logic [10:0] right_reg, right_next;
    logic [15:0] head_out_reg, head_out_next;
    logic        last_reg, last_next;

    nha_pkg::entry_t    rd_entry;
    nha_pkg::tbl_wr_t   tbl_wr;
    nha_pkg::unit_req_t unit_req;
    nha_pkg::unit_rsp_t unit_rsp;

    logic        in_acc;
    logic        out_free;
    logic        push;
    logic        push_last;
    logic [1:0]  push_kind;
    logic [7:0]  push_frame;
    logic [10:0] push_left;
    logic [10:0] push_right;
    logic        advance;
    logic [9:0]  spd;
    logic [10:0] spd_pos;
    logic [10:0] spd_neg;
    logic [15:0] rot_in;
    logic [19:0] slice_prod;

    nha_table u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry),
        .wr       (tbl_wr)
    );

    nha_unit u_unit
    (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign spd     = (tspeed_reg > nha_pkg::SPEED_LIMIT) ? nha_pkg::SPEED_LIMIT : tspeed_reg;
    assign spd_pos = {1'b0, spd};
    assign spd_neg = 11'd0 - spd_pos;
    // turn back toward zero heading
    assign rot_in  = heading_reg[15] ? {1'b0, tstep_reg} : (16'd0 - {1'b0, tstep_reg});
    // (u * 15) >> 16 as (u << 4) - u
    assign slice_prod = {unit_rsp.sum, 4'b0000} - {4'b0000, unit_rsp.sum};

    always_comb
    begin
        own_id_next = own_id_reg;
        ttl_next    = ttl_reg;
        ostep_next  = ostep_reg;
        tstep_next  = tstep_reg;
        tspeed_next = tspeed_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                nha_pkg::CFG_OWN_ID:     own_id_next = cfg_data[3:0];
                nha_pkg::CFG_TTL:        ttl_next    = cfg_data[31:0];
                nha_pkg::CFG_OSTEP:      ostep_next  = cfg_data[14:0];
                nha_pkg::CFG_TSTEP:      tstep_next  = cfg_data[14:0];
                nha_pkg::CFG_TURN_SPEED: tspeed_next = cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        heading_next   = heading_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        match_hit_next = match_hit_reg;
        free_hit_next  = free_hit_reg;
        old_hit_next   = old_hit_reg;
        cnt_next       = cnt_reg;
        nid_next       = nid_reg;
        arrival_next   = arrival_reg;
        sensor_next    = sensor_reg;
        now_next       = now_reg;
        target_next    = target_reg;
        rot_next       = rot_reg;
        match_idx_next = match_idx_reg;
        free_idx_next  = free_idx_reg;
        old_idx_next   = old_idx_reg;
        old_age_next   = old_age_reg;
        fin_kind_next  = fin_kind_reg;
        fin_frame_next = fin_frame_reg;
        fin_left_next  = fin_left_reg;
        fin_right_next = fin_right_reg;

        unit_req   = '0;
        tbl_wr     = '0;
        tbl_wr.idx = idx_reg;
        push       = 1'b0;
        push_last  = 1'b0;
        push_kind  = fin_kind_reg;
        push_frame = fin_frame_reg;
        push_left  = fin_left_reg;
        push_right = fin_right_reg;
        advance    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (operation == nha_pkg::OP_TICK)
                begin
                    unit_req.p = heading_reg;
                    unit_req.q = rot_in;
                end
                else
                begin
                    unit_req.p = arrival_angle;
                    unit_req.q = nha_pkg::align_bias(frame_value[3:0]);
                end
                if (in_acc)
                begin
                    op_next        = operation;
                    nid_next       = frame_value[7:4];
                    arrival_next   = arrival_angle;
                    sensor_next    = arrival_sensor;
                    now_next       = now;
                    target_next    = unit_rsp.sum;
                    idx_next       = '0;
                    match_hit_next = 1'b0;
                    free_hit_next  = 1'b0;
                    old_hit_next   = 1'b0;
                    old_age_next   = '0;
                    cnt_next       = '0;
                    fin_kind_next  = nha_pkg::KIND_REPORT;
                    fin_frame_next = '0;
                    fin_left_next  = '0;
                    fin_right_next = '0;
                    unique case (operation)
                        nha_pkg::OP_FRAME:
                        begin
                            if (frame_error)
                            begin
                                state_next = ST_FINAL;
                            end
                            else if (frame_value[3:0] == nha_pkg::FRAME_BCAST)
                            begin
                                state_next = (frame_value[7:4] != own_id_reg) ? ST_SCAN
                                                                              : ST_FINAL;
                            end
                            else
                            begin
                                state_next = (frame_value[7:4] == own_id_reg) ? ST_ALIGN
                                                                              : ST_FINAL;
                            end
                        end
                        nha_pkg::OP_TICK:
                        begin
                            heading_next   = unit_rsp.sum;
                            rot_next       = rot_in;
                            fin_kind_next  = nha_pkg::KIND_MOTOR;
                            fin_left_next  = heading_reg[15] ? spd_pos : spd_neg;
                            fin_right_next = heading_reg[15] ? spd_neg : spd_pos;
                            state_next     = ST_SCAN;
                        end
                        nha_pkg::OP_SEND:
                        begin
                            fin_kind_next  = nha_pkg::KIND_FRAME;
                            fin_frame_next = {own_id_reg, nha_pkg::FRAME_BCAST};
                            state_next     = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                unit_req.x = now_reg;
                unit_req.y = rd_entry.seen;
                case (op_reg)
                    nha_pkg::OP_FRAME:
                    begin
                        // stop looking once the id is found
                        if (!match_hit_reg)
                        begin
                            if (rd_entry.valid && (rd_entry.id == nid_reg))
                            begin
                                match_hit_next = 1'b1;
                                match_idx_next = idx_reg;
                            end
                            else if (!rd_entry.valid)
                            begin
                                free_hit_next = 1'b1;
                                free_idx_next = idx_reg;
                            end
                            else if (unit_rsp.diff > old_age_reg)
                            begin
                                old_hit_next = 1'b1;
                                old_idx_next = idx_reg;
                                old_age_next = unit_rsp.diff;
                            end
                        end
                    end
                    nha_pkg::OP_TICK:
                    begin
                        unit_req.p = rd_entry.angle;
                        unit_req.q = rot_reg;
                        if (rd_entry.valid)
                        begin
                            tbl_wr.en     = 1'b1;
                            tbl_wr.angle  = unit_rsp.sum;
                            tbl_wr.sensor = {~unit_rsp.sum[15], unit_rsp.sum[14:13]};
                        end
                    end
                    nha_pkg::OP_SEND:
                    begin
                        unit_req.p   = heading_reg;
                        unit_req.q   = rd_entry.angle;
                        unit_req.sub = 1'b1;
                        if (rd_entry.valid && (unit_rsp.diff < ttl_reg)
                            && (cnt_reg != nha_pkg::FRAME_CAP))
                        begin
                            // release the held frame, hold this one
                            if (out_free)
                            begin
                                push           = 1'b1;
                                fin_frame_next = {rd_entry.id, slice_prod[19:16]};
                                cnt_next       = cnt_reg + CW'(1);
                            end
                            else
                            begin
                                advance = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
                if (advance)
                begin
                    idx_next = idx_reg + IW'(1);
                    if (idx_reg == nha_pkg::LAST_IDX)
                    begin
                        state_next = (op_reg == nha_pkg::OP_FRAME) ? ST_WRITE : ST_FINAL;
                    end
                end
            end

            ST_WRITE:
            begin
                tbl_wr.en     = 1'b1;
                tbl_wr.full   = 1'b1;
                tbl_wr.idx    = match_hit_reg ? match_idx_reg :
                                free_hit_reg  ? free_idx_reg  :
                                old_hit_reg   ? old_idx_reg   : '0;
                tbl_wr.id     = nid_reg;
                tbl_wr.angle  = arrival_reg;
                tbl_wr.sensor = sensor_reg;
                tbl_wr.seen   = now_reg;
                state_next    = ST_FINAL;
            end

            ST_ALIGN:
            begin
                unit_req.p   = target_reg;
                unit_req.q   = heading_reg;
                unit_req.sub = 1'b1;
                if (unit_rsp.sum != 16'd0)
                begin
                    heading_next = unit_rsp.sum[15] ? (heading_reg - {1'b0, ostep_reg})
                                                    : (heading_reg + {1'b0, ostep_reg});
                end
                state_next = ST_FINAL;
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        frame_next     = frame_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        head_out_next  = head_out_reg;
        last_next      = last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            kind_next      = push_kind;
            frame_next     = push_frame;
            left_next      = push_left;
            right_next     = push_right;
            head_out_next  = heading_next;
            last_next      = push_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            own_id_reg    <= nha_pkg::OWN_ID_RST;
            ttl_reg       <= nha_pkg::TTL_RST;
            ostep_reg     <= nha_pkg::OSTEP_RST;
            tstep_reg     <= nha_pkg::TSTEP_RST;
            tspeed_reg    <= nha_pkg::TSPEED_RST;
            heading_reg   <= '0;
            op_reg        <= nha_pkg::OP_NONE;
            idx_reg       <= '0;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            old_hit_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            own_id_reg    <= own_id_next;
            ttl_reg       <= ttl_next;
            ostep_reg     <= ostep_next;
            tstep_reg     <= tstep_next;
            tspeed_reg    <= tspeed_next;
            heading_reg   <= heading_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            match_hit_reg <= match_hit_next;
            free_hit_reg  <= free_hit_next;
            old_hit_reg   <= old_hit_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nid_reg       <= nid_next;
        arrival_reg   <= arrival_next;
        sensor_reg    <= sensor_next;
        now_reg       <= now_next;
        target_reg    <= target_next;
        rot_reg       <= rot_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
        old_age_reg   <= old_age_next;
        fin_kind_reg  <= fin_kind_next;
        fin_frame_reg <= fin_frame_next;
        fin_left_reg  <= fin_left_next;
        fin_right_reg <= fin_right_next;
        kind_reg      <= kind_next;
        frame_reg     <= frame_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        head_out_reg  <= head_out_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign frame_out   = frame_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign heading_now = head_out_reg;
    assign last_of_run = last_reg;

    `NHA_ASSERT_NEXT(a_busy_after_req, in_acc && (operation != nha_pkg::OP_NONE), state_reg != ST_IDLE, "request with an operation did not start work")
    `NHA_ASSERT_NEXT(a_idle_after_last, push && push_last, state_reg == ST_IDLE, "sequencer busy after final result")
    `NHA_ASSERT_NEXT(a_heading_hold, !in_acc && (state_reg != ST_ALIGN), $stable(heading_reg), "heading changed outside tick or align")
    `NHA_ASSERT_HOLD(a_write_in_scan, tbl_wr.en, (state_reg == ST_SCAN) || (state_reg == ST_WRITE), "table written outside scan or insert")

endmodule

`default_nettype wire

FILE: rtl/nha_table.sv
// ----------------------------------------------------------------------------
// nha_table
// Neighbour entry storage: one read port and one write port, valid bits reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nha_table
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [nha_pkg::IDX_W-1:0]   rd_idx,
    output nha_pkg::entry_t                  rd_entry,
    input  nha_pkg::tbl_wr_t                 wr
);

    logic [nha_pkg::TABLE_ENTRIES-1:0] valid_reg;
    logic [3:0]  id_reg     [nha_pkg::TABLE_ENTRIES];
    logic [15:0] angle_reg  [nha_pkg::TABLE_ENTRIES];
    logic [2:0]  sensor_reg [nha_pkg::TABLE_ENTRIES];
    logic [31:0] seen_reg   [nha_pkg::TABLE_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en && wr.full)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            angle_reg[wr.idx]  <= wr.angle;
            sensor_reg[wr.idx] <= wr.sensor;
            if (wr.full)
            begin
                id_reg[wr.idx]   <= wr.id;
                seen_reg[wr.idx] <= wr.seen;
            end
        end
    end

    assign rd_entry.valid  = valid_reg[rd_idx];
    assign rd_entry.id     = id_reg[rd_idx];
    assign rd_entry.angle  = angle_reg[rd_idx];
    assign rd_entry.sensor = sensor_reg[rd_idx];
    assign rd_entry.seen   = seen_reg[rd_idx];

endmodule

`default_nettype wire

FILE: rtl/nha_unit.sv
// ----------------------------------------------------------------------------
// nha_unit
// Shared arithmetic: 32-bit age subtractor and 16-bit angle adder-subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module nha_unit
(
    input  nha_pkg::unit_req_t req,
    output nha_pkg::unit_rsp_t rsp
);

    assign rsp.diff = req.x - req.y;
    assign rsp.sum  = req.sub ? (req.p - req.q) : (req.p + req.q);

endmodule

`default_nettype wire
